@@ design/rmq_pkg.sv @@
package rmq_pkg;

  localparam int ELEM_W = 16;
  localparam int NUM_W  = 17;
  localparam int QBITS  = 17;

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

  localparam logic signed [ELEM_W-1:0] Q_MAX = 16'sh7fff;
  localparam logic signed [ELEM_W-1:0] Q_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [ELEM_W-1:0] elem_0;
    logic signed [ELEM_W-1:0] elem_1;
    logic signed [ELEM_W-1:0] elem_2;
    logic signed [ELEM_W-1:0] elem_4;
    logic signed [ELEM_W-1:0] elem_5;
    logic signed [ELEM_W-1:0] elem_6;
    logic signed [ELEM_W-1:0] elem_8;
    logic signed [ELEM_W-1:0] elem_9;
    logic signed [ELEM_W-1:0] elem_10;
  } in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] quat_x;
    logic signed [ELEM_W-1:0] quat_y;
    logic signed [ELEM_W-1:0] quat_z;
    logic signed [ELEM_W-1:0] quat_w;
    logic [1:0]               branch_taken;
    logic                     degenerate;
  } out_t;

endpackage

@@ design/rotation_matrix_to_quaternion_top.sv @@
// Throughput: one matrix per cycle; busy is always low.
// The depth is set by the square root (FRAC_BITS + 9 stages, one root bit each)
// followed by the dividers (17 stages, one quotient bit each).
// Reset (rst_n low, synchronous) clears every valid bit; no result is lost to the
// receiver, which cannot stall.
module rotation_matrix_to_quaternion_top #(
  parameter int FRAC_BITS = 14
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  rmq_pkg::in_t   in_data,
  output logic           out_valid,
  output rmq_pkg::out_t  out_data
);

  localparam int RB  = FRAC_BITS + 9;
  localparam int VW  = 2 * RB;
  localparam int AW  = FRAC_BITS + 18;
  localparam int TW  = FRAC_BITS + 19;
  localparam int NW  = FRAC_BITS + 18;
  localparam int DW  = RB + 1;
  localparam int QB  = rmq_pkg::QBITS;
  localparam int NMW = rmq_pkg::NUM_W;
  localparam int EWD = rmq_pkg::ELEM_W;
  localparam logic signed [TW-1:0] ONE = {{(TW-1){1'b0}}, 1'b1} << FRAC_BITS;

  typedef struct packed {
    logic [1:0]            br;
    logic signed [NMW-1:0] na;
    logic signed [NMW-1:0] nb;
    logic signed [NMW-1:0] nc;
  } side_a_t;

  typedef struct packed {
    logic [1:0]     br;
    logic           deg;
    logic [EWD-1:0] dom;
    logic [2:0]     neg;
    logic [2:0]     zer;
  } side_b_t;

  assign busy = 1'b0;

  // input register
  logic         v0_r;
  rmq_pkg::in_t in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start & ~busy;
    end
    in_r <= in_data;
  end

  // branch select, root argument, numerators
  logic signed [TW-1:0] m0, m5, m10, tr, arg_s;
  logic                 xdom, ydom;
  logic [AW-1:0]        arg_nxt;
  side_a_t              sa_nxt;
  logic signed [NMW-1:0] e1, e2, e4, e6, e8, e9;

  always_comb begin
    m0  = TW'(in_r.elem_0);
    m5  = TW'(in_r.elem_5);
    m10 = TW'(in_r.elem_10);
    e1  = NMW'(in_r.elem_1);
    e2  = NMW'(in_r.elem_2);
    e4  = NMW'(in_r.elem_4);
    e6  = NMW'(in_r.elem_6);
    e8  = NMW'(in_r.elem_8);
    e9  = NMW'(in_r.elem_9);
    tr   = m0 + m5 + m10 + ONE;
    xdom = (m0 > m5) && (m0 > m10);
    ydom = m5 > m10;
    if (tr >= ONE) begin
      arg_s     = tr;
      sa_nxt.br = rmq_pkg::BR_TRACE;
      sa_nxt.na = e9 - e6;
      sa_nxt.nb = e2 - e8;
      sa_nxt.nc = e4 - e1;
    end else if (xdom) begin
      arg_s     = ONE + m0 - m5 - m10;
      sa_nxt.br = rmq_pkg::BR_X;
      sa_nxt.na = e4 + e1;
      sa_nxt.nb = e2 + e8;
      sa_nxt.nc = e9 - e6;
    end else if (ydom) begin
      arg_s     = ONE + m5 - m0 - m10;
      sa_nxt.br = rmq_pkg::BR_Y;
      sa_nxt.na = e4 + e1;
      sa_nxt.nb = e9 + e6;
      sa_nxt.nc = e2 - e8;
    end else begin
      arg_s     = ONE + m10 - m0 - m5;
      sa_nxt.br = rmq_pkg::BR_Z;
      sa_nxt.na = e2 + e8;
      sa_nxt.nb = e6 + e9;
      sa_nxt.nc = e4 - e1;
    end
    arg_nxt = (arg_s < 0) ? '0 : arg_s[AW-1:0];
  end

  logic          v1_r;
  logic [AW-1:0] arg1_r;
  side_a_t       sa1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
    arg1_r <= arg_nxt;
    sa1_r  <= sa_nxt;
  end

  // square root of arg * 2^FRAC_BITS
  logic          sq_vld;
  logic [RB-1:0] root;

  rmq_sqrt #(.RB(RB)) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (v1_r),
    .in_val  (VW'({arg1_r, {FRAC_BITS{1'b0}}})),
    .out_vld (sq_vld),
    .out_root(root)
  );

  // side data delay matching the root stages
  side_a_t sa_dly_r [RB];

  always_ff @(posedge clk) begin
    sa_dly_r[0] <= sa1_r;
    for (int i = 1; i < RB; i++) begin
      sa_dly_r[i] <= sa_dly_r[i-1];
    end
  end

  // divider operands: magnitude << FRAC_BITS + root over 2 * root
  side_a_t               sa_q;
  logic signed [NMW-1:0] nums [3];
  logic [NMW-1:0]        mags [3];
  logic [NW-1:0]         nn_nxt [3];
  side_b_t               sb_nxt;
  logic [RB-2:0]         half;

  always_comb begin
    sa_q    = sa_dly_r[RB-1];
    nums[0] = sa_q.na;
    nums[1] = sa_q.nb;
    nums[2] = sa_q.nc;
    for (int i = 0; i < 3; i++) begin
      sb_nxt.neg[i] = nums[i] < 0;
      sb_nxt.zer[i] = nums[i] == 0;
      mags[i]       = sb_nxt.neg[i] ? NMW'(-nums[i]) : NMW'(nums[i]);
      nn_nxt[i]     = (NW'(mags[i]) << FRAC_BITS) + NW'(root);
    end
    half       = root[RB-1:1];
    sb_nxt.br  = sa_q.br;
    sb_nxt.deg = (sa_q.br != rmq_pkg::BR_TRACE) && (root == '0);
    sb_nxt.dom = (half > (RB-1)'(32767)) ? rmq_pkg::Q_MAX : EWD'(half);
  end

  logic          v2_r;
  logic [NW-1:0] nn_r [3];
  logic [DW-1:0] dd_r;
  side_b_t       sb2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= sq_vld;
    end
    for (int i = 0; i < 3; i++) begin
      nn_r[i] <= nn_nxt[i];
    end
    dd_r  <= {root, 1'b0};
    sb2_r <= sb_nxt;
  end

  // three dividers, one per non-root component
  logic          dv_vld [3];
  logic [QB-1:0] quo [3];
  logic          ovf [3];

  for (genvar j = 0; j < 3; j++) begin : g_div
    rmq_div #(.NW(NW), .DW(DW)) u_div (
      .clk    (clk),
      .rst_n  (rst_n),
      .in_vld (v2_r),
      .in_num (nn_r[j]),
      .in_den (dd_r),
      .out_vld(dv_vld[j]),
      .out_quo(quo[j]),
      .out_ovf(ovf[j])
    );
  end

  side_b_t sb_dly_r [QB];

  always_ff @(posedge clk) begin
    sb_dly_r[0] <= sb2_r;
    for (int i = 1; i < QB; i++) begin
      sb_dly_r[i] <= sb_dly_r[i-1];
    end
  end

  // sign, saturation and placement by branch
  side_b_t              sb_q;
  logic signed [EWD-1:0] part [3];
  rmq_pkg::out_t        res_nxt;

  always_comb begin
    sb_q = sb_dly_r[QB-1];
    for (int i = 0; i < 3; i++) begin
      if (sb_q.deg) begin
        part[i] = sb_q.zer[i] ? '0 : (sb_q.neg[i] ? rmq_pkg::Q_MIN : rmq_pkg::Q_MAX);
      end else if (sb_q.neg[i]) begin
        part[i] = (ovf[i] || quo[i] > QB'(32768)) ? rmq_pkg::Q_MIN : EWD'(-quo[i]);
      end else begin
        part[i] = (ovf[i] || quo[i] > QB'(32767)) ? rmq_pkg::Q_MAX : EWD'(quo[i]);
      end
    end
    res_nxt.branch_taken = sb_q.br;
    res_nxt.degenerate   = sb_q.deg;
    case (sb_q.br)
      rmq_pkg::BR_TRACE: begin
        res_nxt.quat_x = part[0];
        res_nxt.quat_y = part[1];
        res_nxt.quat_z = part[2];
        res_nxt.quat_w = sb_q.dom;
      end
      rmq_pkg::BR_X: begin
        res_nxt.quat_x = sb_q.dom;
        res_nxt.quat_y = part[0];
        res_nxt.quat_z = part[1];
        res_nxt.quat_w = part[2];
      end
      rmq_pkg::BR_Y: begin
        res_nxt.quat_x = part[0];
        res_nxt.quat_y = sb_q.dom;
        res_nxt.quat_z = part[1];
        res_nxt.quat_w = part[2];
      end
      default: begin
        res_nxt.quat_x = part[0];
        res_nxt.quat_y = part[1];
        res_nxt.quat_z = sb_q.dom;
        res_nxt.quat_w = part[2];
      end
    endcase
  end

  // output register
  logic          out_valid_r;
  rmq_pkg::out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_vld[0];
    end
    out_data_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // degenerate results only come from a dominant-element branch
  a_deg_branch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |-> out_data.branch_taken != rmq_pkg::BR_TRACE)
    else $error("degenerate result on trace path");

  // trace path root is never negative
  a_trace_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.branch_taken == rmq_pkg::BR_TRACE |-> out_data.quat_w >= 0)
    else $error("negative w on trace path");

  // zero root gives a zero dominant component (checked on the x branch)
  a_deg_dom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate && out_data.branch_taken == rmq_pkg::BR_X
    |-> out_data.quat_x == 0)
    else $error("degenerate x branch with nonzero x");

endmodule

@@ design/rmq_sqrt.sv @@
// Integer square root, one result bit per register stage.
module rmq_sqrt #(
  parameter int RB = 23
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  logic [2*RB-1:0] in_val,
  output logic            out_vld,
  output logic [RB-1:0]   out_root
);

  localparam int VW = 2 * RB;

  logic          vld_r [RB];
  logic [VW-1:0] rem_r [RB];
  logic [VW-1:0] res_r [RB];

  for (genvar k = 0; k < RB; k++) begin : g_stage
    localparam logic [VW:0] BITV = (VW+1)'(1) << (2 * (RB - 1 - k));
    logic          vin;
    logic [VW-1:0] rin;
    logic [VW-1:0] sin;
    logic [VW:0]   trial;
    logic          ge;
    logic [VW-1:0] rem_nxt;
    logic [VW-1:0] res_nxt;

    if (k == 0) begin : g_first
      assign vin = in_vld;
      assign rin = in_val;
      assign sin = '0;
    end else begin : g_next
      assign vin = vld_r[k-1];
      assign rin = rem_r[k-1];
      assign sin = res_r[k-1];
    end

    // try res + bit against the remainder
    always_comb begin
      trial   = {1'b0, sin} + BITV;
      ge      = {1'b0, rin} >= trial;
      rem_nxt = ge ? VW'({1'b0, rin} - trial) : rin;
      res_nxt = ge ? VW'({1'b0, (sin >> 1)} + BITV) : (sin >> 1);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vin;
      end
      rem_r[k] <= rem_nxt;
      res_r[k] <= res_nxt;
    end
  end

  assign out_vld  = vld_r[RB-1];
  assign out_root = res_r[RB-1][RB-1:0];

endmodule

@@ design/rmq_div.sv @@
// Restoring divider, one quotient bit per register stage, overflow flagged.
module rmq_div #(
  parameter int NW = 32,
  parameter int DW = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  logic [NW-1:0]            in_num,
  input  logic [DW-1:0]            in_den,
  output logic                     out_vld,
  output logic [rmq_pkg::QBITS-1:0] out_quo,
  output logic                     out_ovf
);

  localparam int QB = rmq_pkg::QBITS;
  localparam int EW = NW + DW + QB + 1;

  logic          vld_r [QB];
  logic [NW-1:0] rem_r [QB];
  logic [DW-1:0] den_r [QB];
  logic [QB-1:0] quo_r [QB];
  logic          ovf_r [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int BITP = QB - 1 - k;
    logic          vin;
    logic [NW-1:0] rin;
    logic [DW-1:0] din;
    logic [QB-1:0] qin;
    logic          oin;
    logic [EW-1:0] dsh;
    logic          ge;
    logic [NW-1:0] rem_nxt;
    logic [QB-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign vin = in_vld;
      assign rin = in_num;
      assign din = in_den;
      assign qin = '0;
      // quotient would not fit in QB bits
      assign oin = EW'(in_num) >= (EW'(in_den) << QB);
    end else begin : g_next
      assign vin = vld_r[k-1];
      assign rin = rem_r[k-1];
      assign din = den_r[k-1];
      assign qin = quo_r[k-1];
      assign oin = ovf_r[k-1];
    end

    always_comb begin
      dsh     = EW'(din) << BITP;
      ge      = EW'(rin) >= dsh;
      rem_nxt = ge ? NW'(EW'(rin) - dsh) : rin;
      quo_nxt = qin | (QB'(ge) << BITP);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vin;
      end
      rem_r[k] <= rem_nxt;
      den_r[k] <= din;
      quo_r[k] <= quo_nxt;
      ovf_r[k] <= oin;
    end
  end

  assign out_vld = vld_r[QB-1];
  assign out_quo = quo_r[QB-1];
  assign out_ovf = ovf_r[QB-1];

endmodule
